### rtl/dxt_pkg.sv
// Shared constants, types and helper functions of the DXT block decoder.
package dxt_pkg;

	// Image geometry
	localparam int MAX_IMAGE_DIM = 4096;
	localparam int DIM_W         = 13;
	localparam int COORD_W       = 12;
	localparam int BLK_W         = 10;
	localparam int BCNT_W        = 12;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Block format codes; the unused code decodes as DXT1
	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;

	// Descriptor queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Reciprocals for the constant divisions, exact over the numerator ranges
	localparam int RECIP3      = 683;
	localparam int RECIP3_SHFT = 11;
	localparam int RECIP7      = 2341;
	localparam int RECIP5      = 3277;
	localparam int RECIPA_SHFT = 14;

	// One accepted block with its placement in the image
	typedef struct packed {
		logic [63:0]       alpha_word;
		logic [63:0]       color_word;
		logic [1:0]        fmt;
		logic [BLK_W-1:0]  col;
		logic [BLK_W-1:0]  line;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic              last_block;
	} blk_desc_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// RGB565 to RGB888 by replicating the top bits
	function automatic rgb_t widen565(input logic [15:0] c);
		rgb_t o;
		o.r = {c[15:11], c[15:13]};
		o.g = {c[10:5], c[10:9]};
		o.b = {c[4:0], c[4:2]};
		return o;
	endfunction

	// Zero acts as one, oversize acts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] o;
		if (v == '0)
			o = DIM_W'(1);
		else if (v > DIM_W'(MAX_IMAGE_DIM))
			o = DIM_W'(MAX_IMAGE_DIM);
		else
			o = v;
		return o;
	endfunction

endpackage

### rtl/dxt_front.sv
// Front end: configuration registers, block placement counters, request intake.
module dxt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [63:0]                  alpha_word,
	input  logic [63:0]                  color_word,
	input  logic                         cfg_write,
	input  logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dxt_pkg::DIM_W-1:0]    cfg_data,
	input  logic                         q_full,
	output logic                         q_push,
	output dxt_pkg::blk_desc_t           q_desc
);
	import dxt_pkg::*;

	logic [1:0]       fmt_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [BLK_W-1:0] col_q;
	logic [BLK_W-1:0] line_q;

	logic [DIM_W-1:0]  w_clamp;
	logic [DIM_W-1:0]  h_clamp;
	logic [BCNT_W-1:0] blk_per_row;
	logic [BCNT_W-1:0] blk_rows;
	logic              row_end;
	logic              last_block;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_DXT1;
			width_q  <= DIM_W'(MAX_IMAGE_DIM);
			height_q <= DIM_W'(MAX_IMAGE_DIM);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Block grid size and end-of-row / end-of-image tests
	always_comb begin
		w_clamp     = clamp_dim(width_q);
		h_clamp     = clamp_dim(height_q);
		blk_per_row = BCNT_W'(({1'b0, w_clamp} + (DIM_W+1)'(3)) >> 2);
		blk_rows    = BCNT_W'(({1'b0, h_clamp} + (DIM_W+1)'(3)) >> 2);
		row_end     = (BCNT_W'(col_q) + BCNT_W'(1)) >= blk_per_row;
		last_block  = row_end && ((BCNT_W'(line_q) + BCNT_W'(1)) >= blk_rows);
	end

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_desc.alpha_word = alpha_word;
		q_desc.color_word = color_word;
		q_desc.fmt        = fmt_q;
		q_desc.col        = col_q;
		q_desc.line       = line_q;
		q_desc.width      = w_clamp;
		q_desc.height     = h_clamp;
		q_desc.last_block = last_block;
	end

	// Placement counters step on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (q_push) begin
			if (last_block) begin
				col_q  <= '0;
				line_q <= '0;
			end else if (row_end) begin
				col_q  <= '0;
				line_q <= line_q + BLK_W'(1);
			end else begin
				col_q <= col_q + BLK_W'(1);
			end
		end
	end

endmodule

### rtl/dxt_queue.sv
// Short descriptor queue that decouples the front end from the texel back end.
module dxt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dxt_pkg::blk_desc_t din,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output dxt_pkg::blk_desc_t dout
);
	import dxt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	blk_desc_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign dout  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= din;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

### rtl/dxt_back.sv
// Back end: palette set-up, sixteen-texel emitter and output register.
module dxt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  dxt_pkg::blk_desc_t            q_desc,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [dxt_pkg::COORD_W-1:0]   pixel_x,
	output logic [dxt_pkg::COORD_W-1:0]   pixel_y,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          inside_image,
	output logic                          last_of_block,
	output logic                          end_of_image
);
	import dxt_pkg::*;

	// Set-up stage: widened endpoints and division numerators
	logic             valid_s1;
	blk_desc_t        desc_s1;
	logic [2:0][7:0]  e0_s1;
	logic [2:0][7:0]  e1_s1;
	logic [9:0]       cn2_s1 [3];
	logic [9:0]       cn3_s1 [3];
	logic [10:0]      anum_s1 [6];
	logic             mode8_s1;

	// Emitter stage: full palette, alpha levels and texel counter
	logic             valid_s2;
	blk_desc_t        desc_s2;
	logic [2:0][7:0]  pal_s2 [4];
	logic [7:0]       alev_s2 [8];
	logic [3:0]       cnt_s2;

	// Output register
	logic               out_valid_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [7:0]         r_q;
	logic [7:0]         g_q;
	logic [7:0]         b_q;
	logic [7:0]         a_q;
	logic               inside_q;
	logic               last_q;
	logic               eoi_q;

	logic out_free;
	logic emit;
	logic s2_done;
	logic s2_load;
	logic s1_load;

	// Stage advance
	assign out_free = !out_valid_q || pop;
	assign emit     = valid_s2 && out_free;
	assign s2_done  = emit && (cnt_s2 == 4'd15);
	assign s2_load  = valid_s1 && (!valid_s2 || s2_done);
	assign s1_load  = q_valid && (!valid_s1 || s2_load);
	assign q_pop    = s1_load;

	// Numerators from the queue head
	logic [2:0][7:0] e0_c;
	logic [2:0][7:0] e1_c;
	logic [9:0]      cn2_c [3];
	logic [9:0]      cn3_c [3];
	logic [10:0]     anum_c [6];
	logic [7:0]      a0_c;
	logic [7:0]      a1_c;
	logic            mode8_c;

	always_comb begin
		e0_c    = widen565(q_desc.color_word[15:0]);
		e1_c    = widen565(q_desc.color_word[31:16]);
		a0_c    = q_desc.alpha_word[7:0];
		a1_c    = q_desc.alpha_word[15:8];
		mode8_c = a0_c > a1_c;
		for (int ch = 0; ch < 3; ch++) begin
			cn2_c[ch] = 10'({e0_c[ch], 1'b0}) + 10'(e1_c[ch]) + 10'd1;
			cn3_c[ch] = 10'(e0_c[ch]) + 10'({e1_c[ch], 1'b0}) + 10'd1;
		end
		for (int j = 0; j < 6; j++) begin
			if (mode8_c)
				anum_c[j] = 11'(6 - j) * 11'(a0_c) + 11'(j + 1) * 11'(a1_c);
			else if (j < 4)
				anum_c[j] = 11'(4 - j) * 11'(a0_c) + 11'(j + 1) * 11'(a1_c);
			else
				anum_c[j] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			desc_s1  <= q_desc;
			e0_s1    <= e0_c;
			e1_s1    <= e1_c;
			cn2_s1   <= cn2_c;
			cn3_s1   <= cn3_c;
			anum_s1  <= anum_c;
			mode8_s1 <= mode8_c;
		end
	end

	// Quotients by reciprocal multiplication
	logic [2:0][7:0] pal2_c;
	logic [2:0][7:0] pal3_c;
	logic [7:0]      alev_c [8];
	logic [19:0]     cprod2 [3];
	logic [19:0]     cprod3 [3];
	logic [22:0]     aprod [6];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			cprod2[ch] = 20'(cn2_s1[ch]) * 20'(RECIP3);
			cprod3[ch] = 20'(cn3_s1[ch]) * 20'(RECIP3);
			pal2_c[ch] = 8'(cprod2[ch] >> RECIP3_SHFT);
			pal3_c[ch] = 8'(cprod3[ch] >> RECIP3_SHFT);
		end
		alev_c[0] = desc_s1.alpha_word[7:0];
		alev_c[1] = desc_s1.alpha_word[15:8];
		for (int j = 0; j < 6; j++) begin
			aprod[j] = 23'(anum_s1[j]) * 23'(mode8_s1 ? RECIP7 : RECIP5);
			if (mode8_s1 || j < 4)
				alev_c[j + 2] = 8'(aprod[j] >> RECIPA_SHFT);
			else if (j == 4)
				alev_c[j + 2] = 8'd0;
			else
				alev_c[j + 2] = 8'd255;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			desc_s2   <= desc_s1;
			pal_s2[0] <= e0_s1;
			pal_s2[1] <= e1_s1;
			pal_s2[2] <= pal2_c;
			pal_s2[3] <= pal3_c;
			alev_s2   <= alev_c;
		end
	end

	// Per-texel selection
	logic [5:0]         cbit;
	logic [5:0]         abit;
	logic [5:0]         nbit;
	logic [1:0]         cidx;
	logic [2:0]         aidx;
	logic [3:0]         nib;
	logic [7:0]         a_c;
	logic [COORD_W-1:0] x_c;
	logic [COORD_W-1:0] y_c;

	always_comb begin
		cbit = 6'd32 + {1'b0, cnt_s2, 1'b0};
		abit = 6'd16 + {2'b00, cnt_s2} * 6'd3;
		nbit = {cnt_s2, 2'b00};
		cidx = desc_s2.color_word[cbit +: 2];
		aidx = desc_s2.alpha_word[abit +: 3];
		nib  = desc_s2.alpha_word[nbit +: 4];
		case (desc_s2.fmt)
			FMT_DXT3: a_c = {nib, nib};
			FMT_DXT5: a_c = alev_s2[aidx];
			default:  a_c = 8'd255;
		endcase
		x_c = {desc_s2.col, cnt_s2[1:0]};
		y_c = {desc_s2.line, cnt_s2[3:2]};
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			x_q      <= x_c;
			y_q      <= y_c;
			r_q      <= pal_s2[cidx][2];
			g_q      <= pal_s2[cidx][1];
			b_q      <= pal_s2[cidx][0];
			a_q      <= a_c;
			inside_q <= ({1'b0, x_c} < desc_s2.width) && ({1'b0, y_c} < desc_s2.height);
			last_q   <= cnt_s2 == 4'd15;
			eoi_q    <= (cnt_s2 == 4'd15) && desc_s2.last_block;
		end
	end

	// Stage valids and texel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			cnt_s2      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load)
				valid_s1 <= 1'b1;
			else if (s2_load)
				valid_s1 <= 1'b0;

			if (s2_load) begin
				valid_s2 <= 1'b1;
				cnt_s2   <= '0;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
				cnt_s2   <= '0;
			end else if (emit) begin
				cnt_s2 <= cnt_s2 + 4'd1;
			end

			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty         = !out_valid_q;
	assign pixel_x       = x_q;
	assign pixel_y       = y_q;
	assign red           = r_q;
	assign green         = g_q;
	assign blue          = b_q;
	assign alpha         = a_q;
	assign inside_image  = inside_q;
	assign last_of_block = last_q;
	assign end_of_image  = eoi_q;

	// Checks
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> cnt_s2 == '0)
		else $error("texel counter running with no block in emitter");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		s2_load |=> valid_s2 && cnt_s2 == '0)
		else $error("block loaded into emitter without restarting at texel 0");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !emit |=> $stable(cnt_s2) && valid_s2)
		else $error("emitter moved while output was stalled");

	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eoi_q |-> last_q)
		else $error("end of image flagged away from last texel of block");

endmodule

### rtl/dxt_block_texture_decoder.sv
// Top level of the DXT1/DXT3/DXT5 block texture decoder.
//
// Each request pushed in is one compressed 4x4 block (alpha half and colour half);
// the decoder returns its sixteen RGBA texels in raster order within the block,
// each with its image coordinates and flags for inside-image, last texel of the
// block and end of image. Blocks are placed left to right, then top to bottom,
// wrapping at the configured image size. Colour always uses four-colour mode.
// The texel emitter delivers one texel per cycle while the output register is free
// or being popped; a two-entry descriptor queue and a palette set-up stage let the
// next block be prepared while the current one streams out. A block pushed into an
// idle decoder passes the queue, the set-up stage and the emitter stage before its
// first texel reaches the output register. Configuration is written through
// cfg_write/cfg_index/cfg_data (0 format, 1 width, 2 height) and must only change
// while no block is in flight. No clearing pass after reset.
module dxt_block_texture_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [63:0]                   alpha_word,
	input  logic [63:0]                   color_word,
	output logic                          empty,
	input  logic                          pop,
	output logic [dxt_pkg::COORD_W-1:0]   pixel_x,
	output logic [dxt_pkg::COORD_W-1:0]   pixel_y,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic [7:0]                    alpha,
	output logic                          inside_image,
	output logic                          last_of_block,
	output logic                          end_of_image,
	input  logic                          cfg_write,
	input  logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dxt_pkg::DIM_W-1:0]     cfg_data
);
	import dxt_pkg::*;

	logic      q_full;
	logic      q_push;
	blk_desc_t q_din;
	logic      q_pop;
	logic      q_valid;
	blk_desc_t q_dout;

	dxt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.alpha_word (alpha_word),
		.color_word (color_word),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_desc     (q_din)
	);

	dxt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	dxt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_desc        (q_dout),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.inside_image  (inside_image),
		.last_of_block (last_of_block),
		.end_of_image  (end_of_image)
	);

endmodule

### dv/dxt_block_texture_decoder_tb.sv
// Self-checking testbench for the DXT block texture decoder: directed and random blocks.
module dxt_block_texture_decoder_tb;
	import dxt_pkg::*;

	localparam int LONG_HOLD     = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 9;
	localparam logic [1:0] FMT_UNUSED = 2'd3;

	typedef struct packed {
		logic [63:0] alpha_word;
		logic [63:0] color_word;
	} block_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic [7:0]         a;
		logic               in_img;
		logic               last;
		logic               eoi;
	} texel_t;

	// DUT connections, all inputs known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [63:0]          alpha_word = '0;
	logic [63:0]          color_word = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [COORD_W-1:0]   pixel_x;
	logic [COORD_W-1:0]   pixel_y;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic                 inside_image;
	logic                 last_of_block;
	logic                 end_of_image;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FORMAT;
	logic [DIM_W-1:0]     cfg_data = '0;

	// Predictor copy of configuration and block position
	logic [1:0]       mdl_format = FMT_DXT1;
	logic [DIM_W-1:0] mdl_width  = DIM_W'(MAX_IMAGE_DIM);
	logic [DIM_W-1:0] mdl_height = DIM_W'(MAX_IMAGE_DIM);
	logic [BLK_W-1:0] blk_col  = '0;
	logic [BLK_W-1:0] blk_line = '0;

	block_req_t pending_blocks[$];
	texel_t     expected_texels[$];

	logic push_taken = 1'b0;
	int   sender_idle_pct   = 33;
	int   receiver_idle_pct = 54;
	bit   hold_req = 1'b0;
	int   hold_count = 0;

	int blocks_queued = 0;
	int blocks_accepted = 0;
	int texels_checked = 0;
	int eoi_seen = 0;
	int input_stalls = 0;
	int settings_used = 0;
	int texel_errors = 0;
	int fmt_blocks[4] = '{0, 0, 0, 0};

	dxt_block_texture_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.alpha_word    (alpha_word),
		.color_word    (color_word),
		.empty         (empty),
		.pop           (pop),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.inside_image  (inside_image),
		.last_of_block (last_of_block),
		.end_of_image  (end_of_image),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Predict the sixteen texels of one block, then step the block position
	function automatic void decode_block(input logic [63:0] aw, input logic [63:0] cw);
		int unsigned w, h, bpr, brows, c, r5, g6, b5, a0, a1, x, y, ci, av;
		int unsigned pal[4][3];
		int unsigned alev[8];
		bit row_end, last_blk;
		texel_t t;
		w = (mdl_width == 0) ? 1 : (mdl_width > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : mdl_width;
		h = (mdl_height == 0) ? 1 : (mdl_height > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : mdl_height;
		bpr = (w + 3) / 4;
		brows = (h + 3) / 4;
		row_end = (int'(blk_col) + 1 >= bpr);
		last_blk = row_end && (int'(blk_line) + 1 >= brows);

		// endpoints widened to 8 bits by repeating their top bits
		for (int e = 0; e < 2; e++) begin
			c = cw[16*e +: 16];
			r5 = (c >> 11) & 'h1F;
			g6 = (c >> 5) & 'h3F;
			b5 = c & 'h1F;
			pal[e][0] = ((r5 << 3) | (r5 >> 2)) & 'hFF;
			pal[e][1] = ((g6 << 2) | (g6 >> 4)) & 'hFF;
			pal[e][2] = ((b5 << 3) | (b5 >> 2)) & 'hFF;
		end
		for (int ch = 0; ch < 3; ch++) begin
			pal[2][ch] = (2 * pal[0][ch] + pal[1][ch] + 1) / 3;
			pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch] + 1) / 3;
		end

		// interpolated alpha: eight levels, or six plus fully clear and opaque
		a0 = aw[7:0];
		a1 = aw[15:8];
		alev[0] = a0;
		alev[1] = a1;
		if (a0 > a1) begin
			for (int i = 2; i < 8; i++)
				alev[i] = ((8 - i) * a0 + (i - 1) * a1) / 7;
		end else begin
			for (int i = 2; i < 6; i++)
				alev[i] = ((6 - i) * a0 + (i - 1) * a1) / 5;
			alev[6] = 0;
			alev[7] = 255;
		end

		for (int k = 0; k < 16; k++) begin
			x = blk_col * 4 + (k % 4);
			y = blk_line * 4 + (k / 4);
			ci = cw[32 + 2*k +: 2];
			case (mdl_format)
				FMT_DXT3: av = aw[4*k +: 4] * 17;
				FMT_DXT5: av = alev[aw[16 + 3*k +: 3]];
				default:  av = 255;
			endcase
			t.x      = COORD_W'(x);
			t.y      = COORD_W'(y);
			t.r      = 8'(pal[ci][0]);
			t.g      = 8'(pal[ci][1]);
			t.b      = 8'(pal[ci][2]);
			t.a      = 8'(av);
			t.in_img = (x < w) && (y < h);
			t.last   = (k == 15);
			t.eoi    = (k == 15) && last_blk;
			expected_texels.push_back(t);
		end

		if (last_blk) begin
			blk_col  = '0;
			blk_line = '0;
		end else if (row_end) begin
			blk_col  = '0;
			blk_line = blk_line + 1'b1;
		end else begin
			blk_col = blk_col + 1'b1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			texel_errors++;
		end
	endfunction

	// Sender: offer pending blocks, holding each request until it is taken
	always @(negedge clk) begin : sender
		block_req_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !push_taken) begin
			// request still waiting
		end else if (pending_blocks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
			nxt = pending_blocks.pop_front();
			push       <= 1'b1;
			alpha_word <= nxt.alpha_word;
			color_word <= nxt.color_word;
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: random pops, with one long hold-off to back the decoder up
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_req && hold_count < LONG_HOLD) begin
			pop <= 1'b0;
			hold_count++;
		end else begin
			pop <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Monitor: check texels against the oldest prediction, record accepted blocks
	always @(posedge clk) begin : monitor
		texel_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_texels.size() == 0) begin
					$error("texel with no block pending: x=%0d y=%0d", pixel_x, pixel_y);
					texel_errors++;
				end else begin
					want = expected_texels.pop_front();
					check_field("pixel_x", want.x, pixel_x);
					check_field("pixel_y", want.y, pixel_y);
					check_field("red", want.r, red);
					check_field("green", want.g, green);
					check_field("blue", want.b, blue);
					check_field("alpha", want.a, alpha);
					check_field("inside_image", want.in_img, inside_image);
					check_field("last_of_block", want.last, last_of_block);
					check_field("end_of_image", want.eoi, end_of_image);
					texels_checked++;
					if (end_of_image)
						eoi_seen++;
				end
			end
			if (push && full)
				input_stalls++;
			if (push && !full) begin
				fmt_blocks[mdl_format]++;
				decode_block(alpha_word, color_word);
				blocks_accepted++;
			end
			push_taken <= push && !full;
		end else begin
			push_taken <= 1'b0;
		end
	end

	function automatic void queue_block(input logic [63:0] aw, input logic [63:0] cw);
		block_req_t b;
		b.alpha_word = aw;
		b.color_word = cw;
		pending_blocks.push_back(b);
		blocks_queued++;
	endfunction

	// DXT5 alpha half: two endpoints and indices counting up from a start level
	function automatic logic [63:0] alpha_ramp(input logic [7:0] a0, a1, input int unsigned start);
		logic [63:0] v;
		v = {48'h0, a1, a0};
		for (int k = 0; k < 16; k++)
			v[16 + 3*k +: 3] = 3'(start + k);
		return v;
	endfunction

	function automatic logic [DIM_W-1:0] random_dim();
		case ($urandom_range(7))
			0:       return '0;
			1:       return DIM_W'(1);
			2:       return DIM_W'(MAX_IMAGE_DIM);
			3:       return DIM_W'($urandom_range(8191, MAX_IMAGE_DIM + 1));
			default: return DIM_W'($urandom_range(40, 2));
		endcase
	endfunction

	// Wait for every block to be taken and every texel returned
	task automatic wait_drained();
		do @(negedge clk);
		while (blocks_accepted != blocks_queued || expected_texels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all three registers back to back; called at a falling edge while idle
	task automatic configure(input logic [1:0] fmt, input logic [DIM_W-1:0] w, h);
		cfg_write <= 1'b1;
		cfg_index <= REG_FORMAT;
		cfg_data  <= DIM_W'(fmt);
		@(negedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_write <= 1'b0;
		mdl_format = fmt;
		mdl_width  = w;
		mdl_height = h;
		settings_used++;
		@(posedge clk);
	endtask

	// Stimulus: directed corners, then random phases over varied settings
	initial begin : stimulus
		logic [63:0] aw, cw;
		int n_items;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, colour extremes and every palette index
		queue_block(64'h0, 64'h0);
		queue_block({64{1'b1}}, {64{1'b1}});
		queue_block({$urandom, $urandom}, {32'hE4E4_E4E4, 16'h07E0, 16'hF800});
		wait_drained();

		// one block per row while the column sits past it
		configure(FMT_DXT3, DIM_W'(4), DIM_W'(12));
		queue_block(64'h0, {32'h1B1B_1B1B, 16'hFFFF, 16'h0000});
		queue_block({64{1'b1}}, {32'hE4E4_E4E4, 16'h001F, 16'hFFE0});
		queue_block(64'hFEDC_BA98_7654_3210, {$urandom, $urandom});
		queue_block({$urandom, $urandom}, {$urandom, $urandom});
		wait_drained();

		// DXT5 on an odd-sized image: both alpha modes and their limits
		configure(FMT_DXT5, DIM_W'(5), DIM_W'(5));
		queue_block(alpha_ramp(8'd200, 8'd10, 0), {$urandom, $urandom});
		queue_block(alpha_ramp(8'd10, 8'd200, 0), {$urandom, $urandom});
		queue_block(alpha_ramp(8'd128, 8'd128, 3), {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
		queue_block(alpha_ramp(8'd255, 8'd0, 4), {$urandom, $urandom});
		queue_block(alpha_ramp(8'd0, 8'd255, 2), {$urandom, $urandom});
		queue_block(alpha_ramp(8'd0, 8'd0, 5), {$urandom, $urandom});
		wait_drained();

		// unused format code and zero size: every block ends the image
		configure(FMT_UNUSED, '0, '0);
		repeat (3) queue_block({$urandom, $urandom}, {$urandom, $urandom});
		wait_drained();

		// oversize dimensions clamp to the maximum
		configure(FMT_DXT1, DIM_W'(8191), DIM_W'(8191));
		repeat (2) queue_block({$urandom, $urandom}, {$urandom, $urandom});
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			configure(2'($urandom_range(3)), random_dim(), random_dim());
			sender_idle_pct   = (p < 3) ? 33 : (p < 6) ? 54 : 0;
			receiver_idle_pct = (p < 3) ? 54 : (p < 6) ? 33 : 0;
			if (p == 3)
				hold_req = 1'b1;
			n_items = (p == 3) ? 36 : $urandom_range(34, 24);
			for (int i = 0; i < n_items; i++) begin
				aw = {$urandom, $urandom};
				cw = {$urandom, $urandom};
				case ($urandom_range(7))
					0: aw[15:8] = aw[7:0];
					1: aw = $urandom_range(1) ? {64{1'b1}} : 64'h0;
					2: cw[31:16] = cw[15:0];
					3: cw[63:32] = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
					default: ;
				endcase
				queue_block(aw, cw);
			end
			wait_drained();
		end

		$display("Run covered %0d blocks (DXT1 %0d, DXT3 %0d, DXT5 %0d, unused code %0d)",
			blocks_accepted, fmt_blocks[0], fmt_blocks[1], fmt_blocks[2], fmt_blocks[3]);
		$display("over %0d settings: %0d texels, %0d image ends, %0d stalled input cycles",
			settings_used, texels_checked, eoi_seen, input_stalls);
		if (texel_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
